// File: hdl/pbls_pkg.sv
// ----------------------------------------------------------------------------
// pbls_pkg
// Shared types, operation and status codes for the partitioned list store.
// ----------------------------------------------------------------------------
package pbls_pkg;

   typedef enum logic [3:0] {
      OP_CREATE          = 4'd0,
      OP_APPEND          = 4'd1,
      OP_DROP_LAST       = 4'd2,
      OP_DELETE_VALUE    = 4'd3,
      OP_RESIZE          = 4'd4,
      OP_COUNT           = 4'd5,
      OP_READ            = 4'd6,
      OP_READ_SORTED     = 4'd7,
      OP_READ_ALL        = 4'd8,
      OP_READ_ALL_SORTED = 4'd9,
      OP_RELEASE_ALL     = 4'd10
   } op_type;

   typedef enum logic [3:0] {
      ST_OK            = 4'd0,
      ST_INVALID_SLOT  = 4'd1,
      ST_NO_LIST       = 4'd2,
      ST_EXISTS        = 4'd3,
      ST_BAD_SIZE      = 4'd4,
      ST_OUT_OF_MEMORY = 4'd5,
      ST_FULL          = 4'd6,
      ST_EMPTY         = 4'd7,
      ST_NOT_FOUND     = 4'd8,
      ST_BAD_NEW_SIZE  = 4'd9,
      ST_ALL_EMPTY     = 4'd10
   } status_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic [3:0]         slot;
      logic signed [31:0] value;
      logic signed [7:0]  amount;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data;
      logic               has_data;
      logic [2:0]         element_count;
      logic               last;
   } rsp_type;

   // decoded command handed from front to back
   typedef struct packed {
      op_type             op;
      logic               slot_ok;
      logic [3:0]         slot;
      logic signed [31:0] value;
      logic signed [7:0]  amount;
      status_type         create_st;
   } cmd_type;

   function automatic rsp_type mk_rsp(status_type st, logic signed [31:0] d,
                                      logic h, logic [2:0] c, logic l);
      rsp_type r;
      r.status        = st;
      r.data          = d;
      r.has_data      = h;
      r.element_count = c;
      r.last          = l;
      return r;
   endfunction

endpackage

// File: hdl/pbls_ram.sv
// ----------------------------------------------------------------------------
// pbls_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 60
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/pbls_queue.sv
// ----------------------------------------------------------------------------
// pbls_queue
// Two-entry command queue between the front decoder and the back engine.
// ----------------------------------------------------------------------------
module pbls_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  pbls_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              out_valid,
   output pbls_pkg::cmd_type out_data
);

   pbls_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/pbls_front.sv
// ----------------------------------------------------------------------------
// pbls_front
// Accepts request transfers, drops unused codes, checks slot range and
// create size, and pushes a decoded command into the queue.
// ----------------------------------------------------------------------------
module pbls_front #(
   parameter int SLOTS = 10,
   parameter int DEPTH = 6
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  pbls_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push_valid,
   output pbls_pkg::cmd_type push_data
);

   logic op_used;

   assign req_stall = queue_full;
   assign op_used   = (req_data.operation <= pbls_pkg::OP_RELEASE_ALL);
   assign push_valid = req_valid && op_used;

   always_comb begin
      push_data.op      = pbls_pkg::op_type'(req_data.operation);
      push_data.slot_ok = (req_data.slot != 4'd0) &&
                          ({1'b0, req_data.slot} <= 5'(SLOTS));
      push_data.slot    = req_data.slot - 4'd1;
      push_data.value   = req_data.value;
      push_data.amount  = req_data.amount;
      if (req_data.amount < 8'sd1) begin
         push_data.create_st = pbls_pkg::ST_BAD_SIZE;
      end else if ($signed({req_data.amount[7], req_data.amount}) >
                   $signed(9'(DEPTH))) begin
         push_data.create_st = pbls_pkg::ST_OUT_OF_MEMORY;
      end else begin
         push_data.create_st = pbls_pkg::ST_OK;
      end
   end

endmodule

// File: hdl/pbls_back.sv
// ----------------------------------------------------------------------------
// pbls_back
// Executes commands against the slot table and element RAM; walks lists for
// reads, compaction and sorted output; holds the response register.
// ----------------------------------------------------------------------------
module pbls_back #(
   parameter int SLOTS = 10,
   parameter int DEPTH = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  pbls_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output pbls_pkg::rsp_type rsp_data
);

   localparam int TOTAL = SLOTS * DEPTH;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int NW    = $clog2(TOTAL + 1);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EXEC = 8'b0000_0010,
      S_SUM  = 8'b0000_0100,
      S_CHK  = 8'b0000_1000,
      S_NEXT = 8'b0001_0000,
      S_WAIT = 8'b0010_0000,
      S_USE  = 8'b0100_0000,
      S_EMIT = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      M_READ   = 2'd0,
      M_SORT   = 2'd1,
      M_DFIND  = 2'd2,
      M_DSHIFT = 2'd3
   } mode_type;

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   pbls_pkg::cmd_type  cmd_ff, cmd_in;
   logic               alloc_ff [SLOTS];
   logic               alloc_in [SLOTS];
   logic [CW-1:0]      cap_ff [SLOTS];
   logic [CW-1:0]      cap_in [SLOTS];
   logic [CW-1:0]      fill_ff [SLOTS];
   logic [CW-1:0]      fill_in [SLOTS];
   logic [SW-1:0]      scan_slot_ff, scan_slot_in;
   logic [SW-1:0]      scan_first_ff, scan_first_in;
   logic [SW-1:0]      scan_end_ff, scan_end_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [NW-1:0]      total_ff, total_in;
   logic [NW-1:0]      emitted_ff, emitted_in;
   logic [NW-1:0]      dup_ff, dup_in;
   logic signed [31:0] best_ff, best_in;
   logic signed [31:0] prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pbls_pkg::rsp_type  rsp_ff, rsp_in;

   logic [SW-1:0]      sel_slot;
   logic               s_alloc;
   logic [CW-1:0]      s_cap;
   logic [CW-1:0]      s_fill;
   logic [AW-1:0]      base_addr;
   logic [AW-1:0]      elem_addr;
   logic [AW-1:0]      fill_addr;
   logic               out_free;
   logic               sorted_op;
   logic               last_one;
   logic signed [9:0]  ncap;
   logic [CW+2:0]      fill_ext;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [31:0]        ram_rd;
   logic signed [31:0] rd_word;

   pbls_ram #(
      .WIDTH(32),
      .DEPTH(TOTAL)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (ram_rd)
   );

   assign rd_word   = $signed(ram_rd);
   assign sel_slot  = (state_ff == S_EXEC) ? cmd_ff.slot[SW-1:0] : scan_slot_ff;
   assign s_alloc   = alloc_ff[sel_slot];
   assign s_cap     = cap_ff[sel_slot];
   assign s_fill    = fill_ff[sel_slot];
   assign base_addr = AW'(sel_slot) * AW'(DEPTH);
   assign elem_addr = base_addr + AW'(idx_ff);
   assign fill_addr = base_addr + AW'(s_fill);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sorted_op = (cmd_ff.op == pbls_pkg::OP_READ_SORTED) ||
                      (cmd_ff.op == pbls_pkg::OP_READ_ALL_SORTED);
   assign last_one  = (NW'(emitted_ff + 1'b1) == total_ff);
   assign ncap      = $signed({{(10 - CW){1'b0}}, s_cap}) +
                      $signed({{2{cmd_ff.amount[7]}}, cmd_ff.amount});
   assign fill_ext  = {3'b000, s_fill};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      cmd_in        = cmd_ff;
      alloc_in      = alloc_ff;
      cap_in        = cap_ff;
      fill_in       = fill_ff;
      scan_slot_in  = scan_slot_ff;
      scan_first_in = scan_first_ff;
      scan_end_in   = scan_end_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      total_in      = total_ff;
      emitted_in    = emitted_ff;
      dup_in        = dup_ff;
      best_in       = best_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      cmd_pop       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff - 1'b1;
      wr_data       = cmd_ff.value;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_data;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = pbls_pkg::mk_rsp(pbls_pkg::ST_OK, '0, 1'b0, 3'd0, 1'b1);
               case (cmd_ff.op)
                  pbls_pkg::OP_RELEASE_ALL: begin
                     for (int i = 0; i < SLOTS; i++) begin
                        alloc_in[i] = 1'b0;
                        cap_in[i]   = '0;
                        fill_in[i]  = '0;
                     end
                  end
                  pbls_pkg::OP_READ_ALL, pbls_pkg::OP_READ_ALL_SORTED: begin
                     rsp_valid_in = 1'b0;
                     total_in     = '0;
                     scan_slot_in = '0;
                     state_in     = S_SUM;
                  end
                  default: begin
                     if (!cmd_ff.slot_ok) begin
                        rsp_in.status = pbls_pkg::ST_INVALID_SLOT;
                     end else if (cmd_ff.op == pbls_pkg::OP_CREATE) begin
                        if (s_alloc) begin
                           rsp_in.status = pbls_pkg::ST_EXISTS;
                        end else if (cmd_ff.create_st != pbls_pkg::ST_OK) begin
                           rsp_in.status = cmd_ff.create_st;
                        end else begin
                           alloc_in[sel_slot] = 1'b1;
                           cap_in[sel_slot]   = cmd_ff.amount[CW-1:0];
                           fill_in[sel_slot]  = '0;
                        end
                     end else if (!s_alloc) begin
                        rsp_in.status = pbls_pkg::ST_NO_LIST;
                     end else begin
                        case (cmd_ff.op)
                           pbls_pkg::OP_APPEND: begin
                              if (s_fill >= s_cap) begin
                                 rsp_in.status = pbls_pkg::ST_FULL;
                              end else begin
                                 wr_en             = 1'b1;
                                 wr_addr           = fill_addr;
                                 fill_in[sel_slot] = s_fill + 1'b1;
                              end
                           end
                           pbls_pkg::OP_DROP_LAST: begin
                              if (s_fill == '0) begin
                                 rsp_in.status = pbls_pkg::ST_EMPTY;
                              end else begin
                                 fill_in[sel_slot] = s_fill - 1'b1;
                              end
                           end
                           pbls_pkg::OP_DELETE_VALUE: begin
                              if (s_fill == '0) begin
                                 rsp_in.status = pbls_pkg::ST_EMPTY;
                              end else begin
                                 rsp_valid_in = 1'b0;
                                 mode_in      = M_DFIND;
                                 scan_slot_in = sel_slot;
                                 idx_in       = '0;
                                 state_in     = S_NEXT;
                              end
                           end
                           pbls_pkg::OP_RESIZE: begin
                              if (ncap < 10'sd1) begin
                                 rsp_in.status = pbls_pkg::ST_BAD_NEW_SIZE;
                              end else if (ncap > $signed(10'(DEPTH))) begin
                                 rsp_in.status = pbls_pkg::ST_OUT_OF_MEMORY;
                              end else begin
                                 cap_in[sel_slot] = ncap[CW-1:0];
                                 if (s_fill > ncap[CW-1:0]) begin
                                    fill_in[sel_slot] = ncap[CW-1:0];
                                 end
                              end
                           end
                           pbls_pkg::OP_COUNT: begin
                              if (s_fill == '0) begin
                                 rsp_in.status = pbls_pkg::ST_EMPTY;
                              end else begin
                                 rsp_in.element_count = fill_ext[2:0];
                              end
                           end
                           pbls_pkg::OP_READ, pbls_pkg::OP_READ_SORTED: begin
                              if (s_fill != '0) begin
                                 rsp_valid_in  = 1'b0;
                                 total_in      = NW'(s_fill);
                                 emitted_in    = '0;
                                 scan_slot_in  = sel_slot;
                                 scan_first_in = sel_slot;
                                 scan_end_in   = sel_slot;
                                 idx_in        = '0;
                                 have_prev_in  = 1'b0;
                                 found_in      = 1'b0;
                                 mode_in       = sorted_op ? M_SORT : M_READ;
                                 state_in      = S_NEXT;
                              end
                           end
                           default: begin
                              rsp_valid_in = 1'b0;
                           end
                        endcase
                     end
                  end
               endcase
            end
         end

         S_SUM: begin
            total_in = total_ff + (s_alloc ? NW'(s_fill) : '0);
            if (scan_slot_ff == SW'(SLOTS - 1)) begin
               state_in = S_CHK;
            end else begin
               scan_slot_in = scan_slot_ff + 1'b1;
            end
         end

         S_CHK: begin
            if (total_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = pbls_pkg::mk_rsp(pbls_pkg::ST_ALL_EMPTY, '0, 1'b0, 3'd0, 1'b1);
                  state_in = S_IDLE;
               end
            end else begin
               scan_slot_in  = '0;
               scan_first_in = '0;
               scan_end_in   = SW'(SLOTS - 1);
               idx_in        = '0;
               emitted_in    = '0;
               have_prev_in  = 1'b0;
               found_in      = 1'b0;
               mode_in       = sorted_op ? M_SORT : M_READ;
               state_in      = S_NEXT;
            end
         end

         S_NEXT: begin
            if (s_alloc && (idx_ff < s_fill)) begin
               addr_in  = elem_addr;
               state_in = S_WAIT;
            end else begin
               case (mode_ff)
                  M_DFIND: begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = pbls_pkg::mk_rsp(pbls_pkg::ST_NOT_FOUND, '0, 1'b0,
                                                  3'd0, 1'b1);
                        state_in = S_IDLE;
                     end
                  end
                  M_DSHIFT: begin
                     if (out_free) begin
                        fill_in[sel_slot] = s_fill - 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_in = pbls_pkg::mk_rsp(pbls_pkg::ST_OK, '0, 1'b0, 3'd0, 1'b1);
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     if (scan_slot_ff == scan_end_ff) begin
                        state_in = (mode_ff == M_SORT) ? S_EMIT : S_IDLE;
                     end else begin
                        scan_slot_in = scan_slot_ff + 1'b1;
                        idx_in       = '0;
                     end
                  end
               endcase
            end
         end

         S_WAIT: begin
            state_in = S_USE;
         end

         S_USE: begin
            case (mode_ff)
               M_READ: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = pbls_pkg::mk_rsp(pbls_pkg::ST_OK, rd_word, 1'b1, 3'd0,
                                               last_one);
                     emitted_in = emitted_ff + 1'b1;
                     idx_in     = idx_ff + 1'b1;
                     state_in   = last_one ? S_IDLE : S_NEXT;
                  end
               end
               M_SORT: begin
                  if (!have_prev_ff || (rd_word > prev_ff)) begin
                     if (!found_ff || (rd_word < best_ff)) begin
                        best_in  = rd_word;
                        dup_in   = NW'(1);
                        found_in = 1'b1;
                     end else if (rd_word == best_ff) begin
                        dup_in = dup_ff + 1'b1;
                     end
                  end
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_NEXT;
               end
               M_DFIND: begin
                  if (rd_word == cmd_ff.value) begin
                     mode_in = M_DSHIFT;
                  end
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_NEXT;
               end
               default: begin
                  wr_en    = 1'b1;
                  wr_addr  = addr_ff - 1'b1;
                  wr_data  = ram_rd;
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_NEXT;
               end
            endcase
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = pbls_pkg::mk_rsp(pbls_pkg::ST_OK, best_ff, 1'b1, 3'd0, last_one);
               emitted_in = emitted_ff + 1'b1;
               dup_in     = dup_ff - 1'b1;
               if (last_one) begin
                  state_in = S_IDLE;
               end else if (dup_ff == NW'(1)) begin
                  prev_in      = best_ff;
                  have_prev_in = 1'b1;
                  found_in     = 1'b0;
                  scan_slot_in = scan_first_ff;
                  idx_in       = '0;
                  state_in     = S_NEXT;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         alloc_ff     <= '{default: '0};
         cap_ff       <= '{default: '0};
         fill_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         alloc_ff     <= alloc_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
      end
      mode_ff       <= mode_in;
      cmd_ff        <= cmd_in;
      scan_slot_ff  <= scan_slot_in;
      scan_first_ff <= scan_first_in;
      scan_end_ff   <= scan_end_in;
      idx_ff        <= idx_in;
      addr_ff       <= addr_in;
      total_ff      <= total_in;
      emitted_ff    <= emitted_in;
      dup_ff        <= dup_in;
      best_ff       <= best_in;
      prev_ff       <= prev_in;
      have_prev_ff  <= have_prev_in;
      found_ff      <= found_in;
      rsp_ff        <= rsp_in;
   end

endmodule

// File: hdl/partitioned_bounded_list_store_unit.sv
// ----------------------------------------------------------------------------
// partitioned_bounded_list_store_unit
// SLOTS bounded lists of up to DEPTH words each, with create, append,
// delete, resize, count, plain and sorted reads, and release.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer (valid/stall). Unused operation
//   codes are taken and dropped. rsp_* returns one or more results per
//   command; last marks the final one. Multi-element reads give one result
//   per element.
//   A front decoder feeds a two-entry command queue; the back engine runs one
//   command at a time. Element reads issue the RAM address, wait for the
//   registered read data and then use it, element by element. Delete walks
//   the list the same way, entry by entry. Read all first scans SLOTS slot
//   entries. Sorted reads make one pass over the elements for each distinct
//   value. Reset clears all lists and both channels; stored words stay
//   undefined until appended. While a valid result is stalled by rsp_stall,
//   the result register holds and the engine waits; the queue keeps taking
//   commands until it is full.
// ----------------------------------------------------------------------------
module partitioned_bounded_list_store_unit #(
   parameter int SLOTS = 10,
   parameter int DEPTH = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbls_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbls_pkg::rsp_type rsp_data
);

   logic              queue_full;
   logic              push_valid;
   pbls_pkg::cmd_type push_data;
   logic              cmd_valid;
   pbls_pkg::cmd_type cmd_data;
   logic              cmd_pop;

   pbls_front #(
      .SLOTS(SLOTS),
      .DEPTH(DEPTH)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   pbls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (cmd_pop),
      .out_valid  (cmd_valid),
      .out_data   (cmd_data)
   );

   pbls_back #(
      .SLOTS(SLOTS),
      .DEPTH(DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/pbls_checker.sv
// ----------------------------------------------------------------------------
// pbls_checker
// Port-level checks on the result channel of the list store.
// ----------------------------------------------------------------------------
module pbls_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pbls_pkg::rsp_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_data |->
         rsp_data.status == pbls_pkg::ST_OK && rsp_data.element_count == 3'd0)
      else $error("element result with bad status or count");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != pbls_pkg::ST_OK |->
         rsp_data.last && !rsp_data.has_data)
      else $error("error result not single");

   a_count_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.element_count != 3'd0 |->
         rsp_data.status == pbls_pkg::ST_OK && rsp_data.last)
      else $error("count result malformed");

endmodule

bind partitioned_bounded_list_store_unit pbls_checker u_pbls_checker (.*);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the partitioned bounded list store: directed
// commands, then random list traffic, with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SLOTS = 10;
   localparam int DEPTH = 6;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   pbls_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   pbls_pkg::rsp_type rsp_data;

   partitioned_bounded_list_store_unit #(.SLOTS(SLOTS), .DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   logic signed [31:0] words [SLOTS][DEPTH];
   logic [2:0]         cap [SLOTS];
   logic [2:0]         fill [SLOTS];
   logic               alloc [SLOTS];

   pbls_pkg::rsp_type pending_rsp [$];
   int                mismatches = 0;
   logic              no_stall = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #500000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic pbls_pkg::rsp_type one_rsp(pbls_pkg::status_type st);
      pbls_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void sort_vals(ref logic signed [31:0] v [$]);
      logic signed [31:0] t;
      for (int i = 1; i < v.size(); i++)
         for (int j = i; j > 0 && v[j] < v[j-1]; j--) begin
            t = v[j]; v[j] = v[j-1]; v[j-1] = t;
         end
   endfunction

   task automatic push_list(logic signed [31:0] v [$], pbls_pkg::status_type empty_st);
      pbls_pkg::rsp_type r;
      if (v.size() == 0) begin
         pending_rsp.push_back(one_rsp(empty_st));
         return;
      end
      for (int k = 0; k < v.size(); k++) begin
         r = '0;
         r.status = pbls_pkg::ST_OK;
         r.data = v[k];
         r.has_data = 1'b1;
         r.last = (k == v.size() - 1);
         pending_rsp.push_back(r);
      end
   endtask

   task automatic predict_store(pbls_pkg::req_type q);
      logic signed [31:0] v [$];
      int s, f, nc, i;
      if (q.operation > pbls_pkg::OP_RELEASE_ALL) return;
      if (q.operation == pbls_pkg::OP_RELEASE_ALL) begin
         foreach (alloc[k]) begin alloc[k] = 0; cap[k] = 0; fill[k] = 0; end
         pending_rsp.push_back(one_rsp(pbls_pkg::ST_OK));
         return;
      end
      if (q.operation == pbls_pkg::OP_READ_ALL ||
          q.operation == pbls_pkg::OP_READ_ALL_SORTED) begin
         for (int k = 0; k < SLOTS; k++)
            if (alloc[k]) for (int j = 0; j < fill[k]; j++) v.push_back(words[k][j]);
         if (q.operation == pbls_pkg::OP_READ_ALL_SORTED) sort_vals(v);
         push_list(v, pbls_pkg::ST_ALL_EMPTY);
         return;
      end
      if (q.slot < 1 || q.slot > SLOTS) begin
         pending_rsp.push_back(one_rsp(pbls_pkg::ST_INVALID_SLOT));
         return;
      end
      s = q.slot - 1;
      if (q.operation == pbls_pkg::OP_CREATE) begin
         if (alloc[s]) pending_rsp.push_back(one_rsp(pbls_pkg::ST_EXISTS));
         else if (q.amount < 1) pending_rsp.push_back(one_rsp(pbls_pkg::ST_BAD_SIZE));
         else if (q.amount > DEPTH)
            pending_rsp.push_back(one_rsp(pbls_pkg::ST_OUT_OF_MEMORY));
         else begin
            alloc[s] = 1; cap[s] = 3'(q.amount); fill[s] = 0;
            pending_rsp.push_back(one_rsp(pbls_pkg::ST_OK));
         end
         return;
      end
      if (!alloc[s]) begin
         pending_rsp.push_back(one_rsp(pbls_pkg::ST_NO_LIST));
         return;
      end
      f = fill[s];
      case (q.operation)
         pbls_pkg::OP_APPEND: begin
            if (f >= cap[s]) pending_rsp.push_back(one_rsp(pbls_pkg::ST_FULL));
            else begin
               words[s][f] = q.value; fill[s] = 3'(f + 1);
               pending_rsp.push_back(one_rsp(pbls_pkg::ST_OK));
            end
         end
         pbls_pkg::OP_DROP_LAST: begin
            if (f == 0) pending_rsp.push_back(one_rsp(pbls_pkg::ST_EMPTY));
            else begin
               fill[s] = 3'(f - 1);
               pending_rsp.push_back(one_rsp(pbls_pkg::ST_OK));
            end
         end
         pbls_pkg::OP_DELETE_VALUE: begin
            if (f == 0) pending_rsp.push_back(one_rsp(pbls_pkg::ST_EMPTY));
            else begin
               for (i = 0; i < f && words[s][i] != q.value; i++) ;
               if (i == f) pending_rsp.push_back(one_rsp(pbls_pkg::ST_NOT_FOUND));
               else begin
                  for (i = i + 1; i < f; i++) words[s][i-1] = words[s][i];
                  fill[s] = 3'(f - 1);
                  pending_rsp.push_back(one_rsp(pbls_pkg::ST_OK));
               end
            end
         end
         pbls_pkg::OP_RESIZE: begin
            nc = int'(cap[s]) + int'(q.amount);
            if (nc < 1) pending_rsp.push_back(one_rsp(pbls_pkg::ST_BAD_NEW_SIZE));
            else if (nc > DEPTH)
               pending_rsp.push_back(one_rsp(pbls_pkg::ST_OUT_OF_MEMORY));
            else begin
               cap[s] = 3'(nc);
               if (f > nc) fill[s] = 3'(nc);
               pending_rsp.push_back(one_rsp(pbls_pkg::ST_OK));
            end
         end
         pbls_pkg::OP_COUNT: begin
            if (f == 0) pending_rsp.push_back(one_rsp(pbls_pkg::ST_EMPTY));
            else begin
               pbls_pkg::rsp_type r;
               r = one_rsp(pbls_pkg::ST_OK);
               r.element_count = 3'(f);
               pending_rsp.push_back(r);
            end
         end
         default: begin
            for (int j = 0; j < f; j++) v.push_back(words[s][j]);
            if (q.operation == pbls_pkg::OP_READ_SORTED) sort_vals(v);
            push_list(v, pbls_pkg::ST_OK);
         end
      endcase
   endtask

   task automatic send_item(pbls_pkg::op_type op, logic [3:0] slot,
                            logic signed [31:0] value, logic signed [7:0] amount);
      pbls_pkg::req_type q;
      int gap;
      q.operation = op;
      q.slot = slot;
      q.value = value;
      q.amount = amount;
      gap = no_stall ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_store(q);
   endtask

   task automatic send_raw(logic [3:0] op, logic [3:0] slot);
      pbls_pkg::req_type q;
      q = '0;
      q.operation = op;
      q.slot = slot;
      q.value = $urandom;
      q.amount = $urandom;
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_store(q);
   endtask

   // receiver: random stall per result, check on each transfer
   initial begin
      int hold;
      pbls_pkg::rsp_type e;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         hold = no_stall ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status || rsp_data.data !== e.data ||
                rsp_data.has_data !== e.has_data ||
                rsp_data.element_count !== e.element_count ||
                rsp_data.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   task automatic test_directed();
      send_item(pbls_pkg::OP_CREATE, 0, 0, 3);
      send_item(pbls_pkg::OP_CREATE, 11, 0, 3);
      send_item(pbls_pkg::OP_CREATE, 15, 0, 3);
      send_item(pbls_pkg::OP_APPEND, 1, 5, 0);
      send_item(pbls_pkg::OP_CREATE, 1, 0, 0);
      send_item(pbls_pkg::OP_CREATE, 1, 0, -64);
      send_item(pbls_pkg::OP_CREATE, 1, 0, 7);
      send_item(pbls_pkg::OP_CREATE, 1, 0, 64);
      send_item(pbls_pkg::OP_CREATE, 1, 0, 2);
      send_item(pbls_pkg::OP_CREATE, 1, 0, 2);
      send_item(pbls_pkg::OP_COUNT, 1, 0, 0);
      send_item(pbls_pkg::OP_READ, 1, 0, 0);
      send_item(pbls_pkg::OP_DROP_LAST, 1, 0, 0);
      send_item(pbls_pkg::OP_DELETE_VALUE, 1, 0, 0);
      send_item(pbls_pkg::OP_READ_ALL, 0, 0, 0);
      send_item(pbls_pkg::OP_APPEND, 1, 32'h7fffffff, 0);
      send_item(pbls_pkg::OP_APPEND, 1, 32'h80000000, 0);
      send_item(pbls_pkg::OP_APPEND, 1, -1, 0);
      send_item(pbls_pkg::OP_READ_SORTED, 1, 0, 0);
      send_item(pbls_pkg::OP_RESIZE, 1, 0, -2);
      send_item(pbls_pkg::OP_RESIZE, 1, 0, 64);
      send_item(pbls_pkg::OP_RESIZE, 1, 0, 4);
      send_item(pbls_pkg::OP_RESIZE, 1, 0, -5);
      send_item(pbls_pkg::OP_CREATE, 10, 0, 6);
      send_item(pbls_pkg::OP_READ_ALL_SORTED, 0, 0, 0);
      send_raw(4'd11, 1);
      send_raw(4'd15, 2);
      send_item(pbls_pkg::OP_RELEASE_ALL, 0, 0, 0);
   endtask

   task automatic test_random();
      pbls_pkg::op_type op;
      logic [3:0] slot;
      logic signed [31:0] value;
      logic signed [7:0] amount;
      int r;
      for (int n = 0; n < 310; n++) begin
         if (n == 150) no_stall = 1;
         if (n == 190) no_stall = 0;
         r = $urandom_range(0, 99);
         slot = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
         value = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 7)) - 4;
         amount = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 128) - 64)
                                              : 8'($urandom_range(0, 9) - 2);
         if (r < 12) op = pbls_pkg::OP_CREATE;
         else if (r < 40) op = pbls_pkg::OP_APPEND;
         else if (r < 47) op = pbls_pkg::OP_DROP_LAST;
         else if (r < 57) op = pbls_pkg::OP_DELETE_VALUE;
         else if (r < 64) op = pbls_pkg::OP_RESIZE;
         else if (r < 71) op = pbls_pkg::OP_COUNT;
         else if (r < 79) op = pbls_pkg::OP_READ;
         else if (r < 87) op = pbls_pkg::OP_READ_SORTED;
         else if (r < 92) op = pbls_pkg::OP_READ_ALL;
         else if (r < 97) op = pbls_pkg::OP_READ_ALL_SORTED;
         else op = pbls_pkg::OP_RELEASE_ALL;
         if (r == 99 && n % 2 == 0) send_raw(4'($urandom_range(11, 15)), slot);
         else send_item(op, slot, value, amount);
      end
   endtask

   initial begin
      int guard;
      foreach (alloc[k]) begin alloc[k] = 0; cap[k] = 0; fill[k] = 0; end
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      req_valid <= 1'b0;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (400) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
